// File: rtl/core/unbiased_space_saving_topk_macros.svh
// assertion macros used by the port-level checker
`ifndef UNBIASED_SPACE_SAVING_TOPK_MACROS_SVH
`define UNBIASED_SPACE_SAVING_TOPK_MACROS_SVH

// condition implies consequence in the same cycle
`define USS_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define USS_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: rtl/core/uss_pkg.sv
// shared types and codes for the space-saving top-k block
package uss_pkg;

  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_FILL    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;
  localparam logic [1:0] OUT_DROP    = 2'd3;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] random_draw;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [5:0]  final_slot;
    logic [31:0] key_count;
    logic [31:0] evicted_key;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] count;
    logic [31:0] key;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic scan_next;
    logic hit;
    logic decide;
    logic repl;
    logic drop;
    logic rd_left;
    logic rd_right;
    logic sift_move;
    logic sift_place;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic match;
    logic scan_last;
    logic root_valid;
    logic repl_ok;
    logic lc_ok;
    logic rc_ok;
    logic best_is_pos;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/core/uss_ram.sv
// generic single write, single registered read memory
module uss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/uss_datapath.sv
// slot memory, search, draw test, sift-down and output register
module uss_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  uss_pkg::cmd_t cmd,
  output uss_pkg::sts_t sts,
  input  uss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output uss_pkg::out_t out_data
);
  import uss_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int PW = (AW > 6) ? AW : 6;
  localparam int SW = $bits(slot_t);

  logic [AW-1:0] clr_idx_r, scan_idx_r, pos_r;
  logic [31:0]   key_r, draw_r, evicted_r;
  slot_t         root_r, cur_r, left_r;
  logic          rc_ok_r;
  logic [63:0]   prod_r;
  logic [1:0]    outcome_r;
  out_t          out_r;
  logic          out_valid_r;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;
  logic [SW-1:0] rdata_raw;

  // child indexes, one bit wider to test against the depth
  logic [AW:0] lc, rc;
  assign lc = {pos_r, 1'b1};
  assign rc = {pos_r, 1'b0} + (AW+1)'(2);

  // child selection
  logic        best_l, best_r;
  logic [31:0] best_cnt;
  assign best_l   = left_r.count < cur_r.count;
  assign best_cnt = best_l ? left_r.count : cur_r.count;
  assign best_r   = rc_ok_r && (rdata.count < best_cnt);

  logic [31:0] ones;
  assign ones = '1;

  // draw * (count + 1) as the registered product plus the draw
  logic [63:0] repl_sum;
  assign repl_sum = prod_r + {32'd0, draw_r};

  // matched slot with its count bumped, saturating
  slot_t hit_slot;
  always_comb begin
    hit_slot       = rdata;
    hit_slot.count = (rdata.count == ones) ? ones : rdata.count + 32'd1;
  end

  // memory port steering
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = pos_r;
    wdata = cur_r;
    if (cmd.accept) begin
      re = 1'b1;
    end else if (cmd.scan_next) begin
      re    = 1'b1;
      raddr = scan_idx_r + AW'(1);
    end else if (cmd.rd_left) begin
      re    = 1'b1;
      raddr = lc[AW-1:0];
    end else if (cmd.rd_right) begin
      re    = 1'b1;
      raddr = rc[AW-1:0];
    end
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = '0;
    end else if (cmd.sift_place) begin
      we = 1'b1;
    end else if (cmd.sift_move) begin
      we    = 1'b1;
      wdata = best_r ? rdata : left_r;
    end
  end

  uss_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rdata = slot_t'(rdata_raw);

  // status
  always_comb begin
    sts.clr_last    = clr_idx_r == AW'(ENTRIES - 1);
    sts.match       = rdata.valid && (rdata.key == key_r);
    sts.scan_last   = scan_idx_r == AW'(ENTRIES - 1);
    sts.root_valid  = root_r.valid;
    sts.repl_ok     = (root_r.count == ones) ? (draw_r == '0) : (repl_sum[63:32] == '0);
    sts.lc_ok       = lc < (AW+1)'(ENTRIES);
    sts.rc_ok       = rc < (AW+1)'(ENTRIES);
    sts.best_is_pos = !best_l && !best_r;
    sts.out_busy    = out_valid_r && out_stall;
  end

  // working registers
  logic [PW-1:0] pos_ext;
  assign pos_ext = PW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.accept) begin
      key_r      <= in_data.key;
      draw_r     <= in_data.random_draw;
      scan_idx_r <= '0;
      evicted_r  <= '0;
    end
    if (cmd.scan_next) begin
      scan_idx_r <= scan_idx_r + AW'(1);
      if (scan_idx_r == '0) begin
        root_r <= rdata;
      end
    end
    if (cmd.hit) begin
      cur_r     <= hit_slot;
      pos_r     <= scan_idx_r;
      outcome_r <= OUT_HIT;
      if (scan_idx_r == '0) begin
        root_r <= rdata;
      end
    end
    if (cmd.decide) begin
      if (scan_idx_r == '0) begin
        root_r <= rdata;
      end
      cur_r     <= '{valid: 1'b1, count: 32'd1, key: key_r};
      pos_r     <= '0;
      outcome_r <= OUT_FILL;
    end
    // product of the draw and the root count, tested on the next cycle
    prod_r <= draw_r * root_r.count;
    if (cmd.repl) begin
      cur_r     <= '{valid: 1'b1,
                     count: (root_r.count == ones) ? ones : root_r.count + 32'd1,
                     key: key_r};
      evicted_r <= root_r.key;
      pos_r     <= '0;
      outcome_r <= OUT_REPLACE;
    end
    if (cmd.drop) begin
      cur_r.count <= '0;
      pos_r       <= '0;
      outcome_r   <= OUT_DROP;
    end
    if (cmd.rd_right) begin
      left_r <= rdata;
    end
    if (cmd.rd_left || cmd.rd_right) begin
      rc_ok_r <= sts.rc_ok;
    end
    if (cmd.sift_move) begin
      pos_r <= best_r ? rc[AW-1:0] : lc[AW-1:0];
    end
    if (cmd.load_out) begin
      out_r.outcome     <= outcome_r;
      out_r.final_slot  <= pos_ext[5:0];
      out_r.key_count   <= cur_r.count;
      out_r.evicted_key <= evicted_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// File: rtl/core/uss_ctrl.sv
// sequencer: clearing pass, search, draw test and sift-down steps
module uss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output uss_pkg::cmd_t cmd,
  input  uss_pkg::sts_t sts
);
  import uss_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_MUL, S_TEST,
    S_LEFT, S_RIGHT, S_CMP, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_LEFT;
        end else if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DECIDE: begin
        // root arrives in the same cycle only for a single-slot scan
        if (!sts.root_valid) begin
          cmd.decide = 1'b1;
          state_nxt  = S_LEFT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_TEST;
      S_TEST: begin
        if (sts.repl_ok) begin
          cmd.repl  = 1'b1;
          state_nxt = S_LEFT;
        end else begin
          cmd.drop  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_LEFT: begin
        if (sts.lc_ok) begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_RIGHT;
        end else begin
          cmd.sift_place = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      S_RIGHT: begin
        cmd.rd_right = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (sts.best_is_pos) begin
          cmd.sift_place = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd.sift_move = 1'b1;
          state_nxt     = S_LEFT;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;
endmodule

// File: rtl/core/unbiased_space_saving_topk.sv
// top level of the unbiased space-saving heavy-hitter counter
//   channel | direction | payload        | handshake
//   in_     | input     | uss_pkg::in_t  | in_valid, in_stall
//   out_    | output    | uss_pkg::out_t | out_valid, out_stall
// after reset a clearing pass writes every slot, with in_stall high
// a transaction is accepted in S_IDLE, then S_SCAN searches the slots in order up to a match or the last slot
// a miss fills an empty root in S_DECIDE, or runs the draw test through S_DECIDE, S_MUL and S_TEST
// each sift level steps through S_LEFT, S_RIGHT and S_CMP on the single read port, a leaf only S_LEFT, a drop none
// S_FINISH then posts the result, and the next transaction is taken while it waits
// a result that is still stalled holds only the final step of the next transaction
module unbiased_space_saving_topk #(
  parameter int ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  uss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output uss_pkg::out_t out_data
);
  import uss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  uss_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

// File: rtl/core/uss_checker.sv
// port-level checks for the top-k block, bound to the top level
`include "unbiased_space_saving_topk_macros.svh"

module uss_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input uss_pkg::out_t out_data
);
  import uss_pkg::*;

  // a stalled result stays offered
  `USS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // an accepted transaction keeps the input busy on the next cycle
  `USS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // a dropped key reports no slot and no count
  `USS_ASSERT_IMPL(a_drop, clk, rst_n, out_valid && out_data.outcome == OUT_DROP,
                   out_data.key_count == '0 && out_data.final_slot == '0)
  // a fresh key in an empty root always rests with count one and evicts nothing
  `USS_ASSERT_IMPL(a_fill, clk, rst_n, out_valid && out_data.outcome == OUT_FILL,
                   out_data.key_count == 32'd1 && out_data.evicted_key == '0)
endmodule

bind unbiased_space_saving_topk uss_checker u_uss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/topk_checker.sv
// checker that predicts and compares space-saving top-k results
module topk_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  uss_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  uss_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            result_count,
  output int            replace_count,
  output int            drop_count
);
  import uss_pkg::*;

  localparam int SLOTS = 64;

  logic [31:0] heap_key [SLOTS];
  logic [31:0] heap_cnt [SLOTS];
  logic        heap_vld [SLOTS];
  out_t        expected_results [$];

  // swap two heap slots
  function automatic void swap_slots(input int a, input int b);
    logic [31:0] k;
    logic [31:0] c;
    logic        v;
    k = heap_key[a]; c = heap_cnt[a]; v = heap_vld[a];
    heap_key[a] = heap_key[b]; heap_cnt[a] = heap_cnt[b]; heap_vld[a] = heap_vld[b];
    heap_key[b] = k; heap_cnt[b] = c; heap_vld[b] = v;
  endfunction

  // push a slot toward the leaves, return where it rests
  function automatic int settle_slot(input int start);
    int pos;
    int lc;
    int rc;
    int best;
    pos = start;
    forever begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < SLOTS && heap_cnt[lc] < heap_cnt[best]) best = lc;
      if (rc < SLOTS && heap_cnt[rc] < heap_cnt[best]) best = rc;
      if (best == pos) return pos;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  // predict the result of one transaction
  function automatic out_t count_key(input in_t item);
    out_t        r;
    int          idx;
    int          s;
    logic [32:0] nextc;
    logic [64:0] prod;
    r = '0;
    idx = -1;
    for (int i = 0; i < SLOTS; i++)
      if (idx < 0 && heap_vld[i] && heap_key[i] == item.key) idx = i;
    if (idx >= 0) begin
      if (heap_cnt[idx] != 32'hFFFF_FFFF) heap_cnt[idx] = heap_cnt[idx] + 1;
      s = settle_slot(idx);
      r.outcome = OUT_HIT; r.final_slot = s[5:0]; r.key_count = heap_cnt[s];
    end else if (!heap_vld[0]) begin
      heap_key[0] = item.key; heap_cnt[0] = 32'd1; heap_vld[0] = 1'b1;
      s = settle_slot(0);
      r.outcome = OUT_FILL; r.final_slot = s[5:0]; r.key_count = heap_cnt[s];
    end else begin
      nextc = {1'b0, heap_cnt[0]} + 33'd1;
      prod = {33'd0, item.random_draw} * {32'd0, nextc};
      if (prod < 65'h1_0000_0000) begin
        r.evicted_key = heap_key[0];
        heap_key[0] = item.key;
        heap_cnt[0] = nextc[32] ? 32'hFFFF_FFFF : nextc[31:0];
        s = settle_slot(0);
        r.outcome = OUT_REPLACE; r.final_slot = s[5:0]; r.key_count = heap_cnt[s];
      end else begin
        r.outcome = OUT_DROP;
      end
    end
    return r;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        heap_key[i] = '0; heap_cnt[i] = '0; heap_vld[i] = 1'b0;
      end
      expected_results.delete();
      fail_count <= 0; result_count <= 0; replace_count <= 0; drop_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.outcome == OUT_REPLACE) replace_count <= replace_count + 1;
          if (want.outcome == OUT_DROP) drop_count <= drop_count + 1;
          if (want !== out_data) begin
            $display("%0t: mismatch expected outcome %0d slot %0d count %h evicted %h",
                     $time, want.outcome, want.final_slot, want.key_count, want.evicted_key);
            $display("%0t:          actual  outcome %0d slot %0d count %h evicted %h",
                     $time, out_data.outcome, out_data.final_slot, out_data.key_count,
                     out_data.evicted_key);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(count_key(in_data));
      pending_count <= expected_results.size();
    end
  end
endmodule

// File: sim/testbench.sv
// stimulus and verdict for the space-saving top-k block
module testbench;
  import uss_pkg::*;

  localparam int ITEMS = 1500;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count, pending_count, result_count, replace_count, drop_count;
  int   cycles = 0;
  bit   quiet_phase = 1'b0;
  logic [31:0] hot_keys [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unbiased_space_saving_topk dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  topk_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_count, .result_count, .replace_count, .drop_count
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    @(posedge clk iff rst_n);
    while (!quiet_phase) begin
      n = $urandom_range(1, 12);
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // send one transaction, with an optional sender gap first
  task automatic send_item(input logic [31:0] k, input logic [31:0] d);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{key: k, random_draw: d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // skewed key choice so that hits, fills and replacements all occur
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return hot_keys[$urandom_range(0, 3)];
    if (r < 80) return hot_keys[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_draw();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 255) << $urandom_range(16, 26);
    if (r == 4) return 32'd0;
    if (r == 5) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    for (int i = 0; i < 16; i++) hot_keys[i] = $urandom;
    hot_keys[0] = 32'hFFFF_FFFF;
    hot_keys[1] = 32'h0000_0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: all-ones and zero keys, fills, hits, extreme draws
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h0000_0000, 32'h0000_0000);
    send_item(32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < 5; i++) send_item(32'hA5A5_0000 + i, 32'hFFFF_FFFF);
    send_item(32'h0000_0000, 32'h8000_0000);
    send_item(32'h5555_AAAA, 32'h0000_0001);
    send_item(32'hAAAA_5555, 32'h7FFF_FFFF);
    for (int i = 0; i < 10; i++) send_item(32'hFFFF_FFFF, $urandom);
    // random
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS - 150) quiet_phase = 1'b1;
      send_item(pick_key(), pick_draw());
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("covered %0d results, %0d replacements and %0d drops", result_count,
             replace_count, drop_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
